@@ sv/wgm_pkg.sv @@
`default_nettype none

package wgm_pkg;

    // Number of mask symbols the cell row can hold.
    localparam int MASK_DEPTH = 32;
    // Bits of a mask or text symbol that take part in a compare.
    localparam int SYMBOL_BITS = 16;
    // Width of the text length counter and of the reported length.
    localparam int COUNT_BITS = 16;
    // Width of the mask fill count, which must be able to hold MASK_DEPTH itself.
    localparam int MCNT_BITS = $clog2(MASK_DEPTH + 1);

    localparam logic [SYMBOL_BITS-1:0] STAR_CODE      = SYMBOL_BITS'(42);
    localparam logic [SYMBOL_BITS-1:0] ANY_RESET      = SYMBOL_BITS'(63);
    localparam logic [SYMBOL_BITS-1:0] CHAR_UPPER_A   = SYMBOL_BITS'(65);
    localparam logic [SYMBOL_BITS-1:0] CHAR_UPPER_Z   = SYMBOL_BITS'(90);
    localparam logic [SYMBOL_BITS-1:0] CASE_OFFSET    = SYMBOL_BITS'(32);
    localparam logic [COUNT_BITS-1:0]  COUNT_CAP      = '1;

    // Kind of an input transfer, carried in tuser.
    localparam logic MODE_MASK = 1'b0;
    localparam logic MODE_TEXT = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_ANY_SYMBOL = 1'b0;
    localparam logic CFG_CASE_FOLD  = 1'b1;

    typedef enum logic [1:0] {
        STATUS_MATCH    = 2'd0,
        STATUS_NO_MATCH = 2'd1,
        STATUS_OVERFLOW = 2'd2
    } t_status;

    // Values shared by every cell of the row in a cycle.
    typedef struct packed {
        logic [SYMBOL_BITS-1:0] wr_sym;
        logic [SYMBOL_BITS-1:0] text_sym_folded;
        logic [SYMBOL_BITS-1:0] any_symbol;
        logic                   case_fold;
    } t_bcast;

    // Update of the active position bits.
    typedef struct packed {
        logic step;
        logic restart;
    } t_act_ctl;

    // Maps A-Z onto a-z when folding is on.
    function automatic logic [SYMBOL_BITS-1:0] fold_sym(input logic [SYMBOL_BITS-1:0] c,
                                                        input logic en);
        logic [SYMBOL_BITS-1:0] r;
        r = c;
        if (en && (c inside {[CHAR_UPPER_A:CHAR_UPPER_Z]})) begin
            r = c + CASE_OFFSET;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ sv/wildcard_glob_matcher_top.sv @@
`default_nettype none

// Wildcard mask matcher. A mask is loaded as a run of transfers with tuser 0, one symbol
// each, closed by tlast; text then streams in with tuser 1, one symbol each, and the
// transfer with tlast yields one result: tuser 0 match, 1 no match, 2 mask longer than
// the store, with tdata holding the text length (saturating) on a match and 0 otherwise.
// '*' matches any run, the configured any-symbol matches one symbol, every other symbol
// matches itself, optionally folding A-Z onto a-z. A text matches if it matches some
// prefix of the mask. A new transfer is taken in every cycle unless input is stalled:
// the mask is held in a row of cells, one per position, and the whole set of
// live positions moves once per text symbol, with star closure rippling along the row.
// A result sits in an output register; input stalls only while that register is full
// and the downstream side is not ready. Configuration writes are taken at any time but
// should only be issued while the block is idle.
module wildcard_glob_matcher_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration write: index 0 any-symbol, index 1 case fold.
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    // Input stream.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [15:0] symbol
    input  wire logic        s_axis_tuser,   // [0] mode
    input  wire logic        s_axis_tlast,
    // Result stream.
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [15:0] matched_length
    output logic [1:0]       m_axis_tuser    // [1:0] status
);

    localparam int D = wgm_pkg::MASK_DEPTH;

    // Configuration registers.
    logic [wgm_pkg::SYMBOL_BITS-1:0] r_any_symbol;
    logic                            r_case_fold;

    // Mask bookkeeping.
    logic [wgm_pkg::MCNT_BITS-1:0]   r_mask_count, n_mask_count;
    logic [wgm_pkg::MCNT_BITS-1:0]   eff_count;
    logic                            r_overflow, n_overflow;
    logic                            r_closed, n_closed;

    // Text bookkeeping.
    logic [wgm_pkg::COUNT_BITS-1:0]  r_text_count, n_text_count;
    logic                            r_tail;
    logic                            n_tail;

    // Output register.
    logic                            r_out_valid;
    wgm_pkg::t_status                r_status, n_status;
    logic [15:0]                     r_len, n_len;

    logic                            accept;
    logic                            mask_wr;
    logic                            text_step;
    logic                            text_end;
    logic                            any_active;

    wgm_pkg::t_bcast                 bcast;
    wgm_pkg::t_act_ctl               act_ctl;
    logic [D:0]                      carry;
    logic [D:0]                      adv;
    logic [D-1:0]                    next_act;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_any_symbol <= wgm_pkg::ANY_RESET;
            r_case_fold  <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                wgm_pkg::CFG_ANY_SYMBOL: r_any_symbol <= i_cfg_data[wgm_pkg::SYMBOL_BITS-1:0];
                wgm_pkg::CFG_CASE_FOLD:  r_case_fold  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // The output register frees itself in the same cycle it is taken.
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign mask_wr       = accept && (s_axis_tuser == wgm_pkg::MODE_MASK);
    assign text_step     = accept && (s_axis_tuser == wgm_pkg::MODE_TEXT);
    assign text_end      = text_step && s_axis_tlast;

    // A closed mask is dropped when the next mask symbol comes in.
    assign eff_count = r_closed ? '0 : r_mask_count;

    always_comb begin
        n_mask_count = r_mask_count;
        n_overflow   = r_overflow;
        n_closed     = r_closed;
        if (mask_wr) begin
            n_overflow = r_closed ? 1'b0 : r_overflow;
            if (eff_count < wgm_pkg::MCNT_BITS'(D)) begin
                n_mask_count = eff_count + 1'b1;
            end else begin
                n_mask_count = eff_count;
                n_overflow   = 1'b1;
            end
            n_closed = s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask_count <= '0;
            r_overflow   <= 1'b0;
            r_closed     <= 1'b0;
        end else begin
            r_mask_count <= n_mask_count;
            r_overflow   <= n_overflow;
            r_closed     <= n_closed;
        end
    end

    always_comb begin
        bcast.wr_sym          = s_axis_tdata[wgm_pkg::SYMBOL_BITS-1:0];
        bcast.text_sym_folded = wgm_pkg::fold_sym(s_axis_tdata[wgm_pkg::SYMBOL_BITS-1:0],
                                                  r_case_fold);
        bcast.any_symbol      = r_any_symbol;
        bcast.case_fold       = r_case_fold;
        act_ctl.restart       = mask_wr || text_end;
        act_ctl.step          = text_step;
    end

    // The row of cells. Stars pass liveness to the right through carry; a consumed text
    // symbol moves liveness to the right through adv.
    assign carry[0] = 1'b0;
    assign adv[0]   = 1'b0;

    for (genvar i = 0; i < D; i++) begin : g_cell
        wgm_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_init  ((i == 0) ? 1'b1 : 1'b0),
            .i_wr_en (mask_wr && (eff_count == wgm_pkg::MCNT_BITS'(i))),
            .i_valid (r_mask_count > wgm_pkg::MCNT_BITS'(i)),
            .i_bcast (bcast),
            .i_ctl   (act_ctl),
            .i_carry (carry[i]),
            .i_adv   (adv[i]),
            .o_carry (carry[i+1]),
            .o_adv   (adv[i+1]),
            .o_next  (next_act[i])
        );
    end

    // The position past the last cell, reached by a full mask, only collects liveness from its left.
    assign n_tail = adv[D];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tail <= 1'b0;
        end else if (act_ctl.restart) begin
            r_tail <= 1'b0;
        end else if (act_ctl.step) begin
            r_tail <= n_tail;
        end
    end

    assign any_active   = (|next_act) || n_tail;
    assign n_text_count = (r_text_count == wgm_pkg::COUNT_CAP) ? r_text_count
                                                               : r_text_count + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_count <= '0;
        end else if (act_ctl.restart) begin
            r_text_count <= '0;
        end else if (text_step) begin
            r_text_count <= n_text_count;
        end
    end

    always_comb begin
        n_len = '0;
        if (r_overflow) begin
            n_status = wgm_pkg::STATUS_OVERFLOW;
        end else if (any_active && (r_mask_count != '0)) begin
            n_status = wgm_pkg::STATUS_MATCH;
            n_len    = 16'(n_text_count);
        end else begin
            n_status = wgm_pkg::STATUS_NO_MATCH;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (text_end) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (text_end) begin
            r_status <= n_status;
            r_len    <= n_len;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_len;
    assign m_axis_tuser  = r_status;

endmodule

`default_nettype wire

@@ sv/wgm_cell.sv @@
`default_nettype none

// One mask position: holds its mask symbol and whether it is active.
module wgm_cell (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_init,
    input  wire logic             i_wr_en,
    input  wire logic             i_valid,
    input  wire wgm_pkg::t_bcast  i_bcast,
    input  wire wgm_pkg::t_act_ctl i_ctl,
    input  wire logic             i_carry,
    input  wire logic             i_adv,
    output logic                  o_carry,
    output logic                  o_adv,
    output logic                  o_next
);

    logic [wgm_pkg::SYMBOL_BITS-1:0] r_sym;
    logic                            r_act;
    logic                            n_act;
    logic                            is_any;
    logic                            is_star;
    logic                            closed;
    logic                            lit_eq;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_sym <= i_bcast.wr_sym;
        end
    end

    always_comb begin
        is_any  = (r_sym == i_bcast.any_symbol);
        is_star = (r_sym == wgm_pkg::STAR_CODE) && !is_any;
        lit_eq  = (wgm_pkg::fold_sym(r_sym, i_bcast.case_fold) == i_bcast.text_sym_folded);
        // A star reached by the left neighbor also makes this position live.
        closed  = r_act | i_carry;
        o_carry = i_valid & closed & is_star;
        o_adv   = i_valid & closed & !is_star & (is_any | lit_eq);
        n_act   = o_carry | i_adv;
        o_next  = n_act;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= i_init;
        end else if (i_ctl.restart) begin
            r_act <= i_init;
        end else if (i_ctl.step) begin
            r_act <= n_act;
        end
    end

endmodule

`default_nettype wire

@@ sv/wgm_checker.sv @@
`default_nettype none

module wgm_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        s_axis_tuser,
    input wire logic        s_axis_tlast,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [15:0] m_axis_tdata,
    input wire logic [1:0]  m_axis_tuser
);

    // A waiting result is not withdrawn.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // A new result follows a transfer of the last text symbol.
    a_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready && s_axis_tlast
                                       && (s_axis_tuser == wgm_pkg::MODE_TEXT)))
        else $error("result without a closing text transfer");

    // Only a match carries a length, and a match always covers at least one symbol.
    a_len_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != wgm_pkg::STATUS_MATCH) |-> m_axis_tdata == 16'd0)
        else $error("length on a failed match");

    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == wgm_pkg::STATUS_MATCH) |-> m_axis_tdata != 16'd0)
        else $error("match with zero length");

    // After reset no result is pending.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result pending after reset");

endmodule

bind wildcard_glob_matcher_top wgm_checker u_wgm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

    localparam int CYCLE_LIMIT  = 60000;
    localparam int REPORT_LIMIT = 10;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 8;
    localparam int TEXT_MAX     = 40;

    // Lowercase letters used by the directed part.
    localparam logic [wgm_pkg::SYMBOL_BITS-1:0] CH_A =
        wgm_pkg::CHAR_UPPER_A + wgm_pkg::CASE_OFFSET;
    localparam logic [wgm_pkg::SYMBOL_BITS-1:0] CH_B = CH_A + wgm_pkg::SYMBOL_BITS'(1);
    localparam logic [wgm_pkg::SYMBOL_BITS-1:0] CH_C = CH_A + wgm_pkg::SYMBOL_BITS'(2);
    localparam logic [wgm_pkg::SYMBOL_BITS-1:0] CH_D = CH_A + wgm_pkg::SYMBOL_BITS'(3);
    localparam logic [wgm_pkg::SYMBOL_BITS-1:0] CH_X = CH_A + wgm_pkg::SYMBOL_BITS'(23);

    // Live set with only position zero.
    localparam logic [wgm_pkg::MASK_DEPTH:0] LIVE_START = {{wgm_pkg::MASK_DEPTH{1'b0}}, 1'b1};

    // One input transfer: mode travels in tuser, the final symbol of a run in tlast.
    typedef struct {
        logic                            mode;
        logic [wgm_pkg::SYMBOL_BITS-1:0] symbol;
        logic                            last;
    } t_sym_item;

    // One result: status in tuser, length in tdata.
    typedef struct packed {
        wgm_pkg::t_status               status;
        logic [wgm_pkg::COUNT_BITS-1:0] length;
    } t_verdict;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_valid   = 1'b0;
    logic        i_cfg_index   = wgm_pkg::CFG_ANY_SYMBOL;
    logic [15:0] i_cfg_data    = '0;
    logic        s_axis_tvalid = 1'b0;
    logic [15:0] s_axis_tdata  = '0;
    logic        s_axis_tuser  = wgm_pkg::MODE_MASK;
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tready = 1'b0;
    wire         o_cfg_ready;
    wire         s_axis_tready;
    wire         m_axis_tvalid;
    wire  [15:0] m_axis_tdata;
    wire  [1:0]  m_axis_tuser;

    wildcard_glob_matcher_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // Symbols waiting for the driver, and match verdicts waiting for the monitor.
    t_sym_item symbol_queue[$];
    t_verdict  awaited_verdicts[$];
    int        items_queued = 0;
    int        mismatches   = 0;
    int        cycle_count  = 0;

    // When set, neither side inserts idle cycles any more.
    bit        calm = 1'b0;
    // Each increment asks the receiver for one long hold-off.
    int        long_hold_tickets = 0;
    int        long_hold_served  = 0;
    int        hold_left         = 0;

    // Driver bookkeeping. drv_holding is set with a blocking assignment so that the
    // sequencer never sees an empty queue while the popped symbol is still in flight.
    t_sym_item drv_item;
    bit        drv_holding = 1'b0;
    int        tx_idle_left = 0;

    // Shadow of the matcher: configuration, stored mask and the set of live positions.
    // Bit i of match_live means that i mask symbols have been consumed so far.
    logic [wgm_pkg::SYMBOL_BITS-1:0] shadow_any  = wgm_pkg::ANY_RESET;
    logic                            shadow_fold = 1'b0;
    logic [wgm_pkg::SYMBOL_BITS-1:0] shadow_mask [wgm_pkg::MASK_DEPTH];
    int                              shadow_fill = 0;
    logic [wgm_pkg::MASK_DEPTH:0]    match_live  = LIVE_START;
    logic [wgm_pkg::COUNT_BITS-1:0]  text_len    = '0;
    logic                            mask_spill  = 1'b0;
    logic                            mask_sealed = 1'b0;

    // Scratch mask shared by the stimulus helpers.
    logic [wgm_pkg::SYMBOL_BITS-1:0] mask_draft[$];

    function automatic logic [wgm_pkg::SYMBOL_BITS-1:0] lower_if_folding(
        input logic [wgm_pkg::SYMBOL_BITS-1:0] c);
        if (shadow_fold && c >= wgm_pkg::CHAR_UPPER_A && c <= wgm_pkg::CHAR_UPPER_Z) begin
            return c + wgm_pkg::CASE_OFFSET;
        end
        return c;
    endfunction

    // Advances the shadow by one accepted transfer and records any verdict it yields.
    task automatic match_step(input t_sym_item it);
        logic [wgm_pkg::MASK_DEPTH:0]    nxt;
        logic [wgm_pkg::SYMBOL_BITS-1:0] m;
        t_verdict                        v;
        if (it.mode == wgm_pkg::MODE_MASK) begin
            // A mask symbol after a closed mask starts a new mask.
            if (mask_sealed) begin
                shadow_fill = 0;
                mask_spill  = 1'b0;
                mask_sealed = 1'b0;
            end
            if (shadow_fill < wgm_pkg::MASK_DEPTH) begin
                shadow_mask[shadow_fill] = it.symbol;
                shadow_fill++;
            end else begin
                mask_spill = 1'b1;
            end
            if (it.last) begin
                mask_sealed = 1'b1;
            end
            // Any text in progress is abandoned.
            match_live = LIVE_START;
            text_len   = '0;
        end else begin
            // A live star also makes the position after it live; the ascending walk
            // lets this ripple through a run of stars.
            for (int i = 0; i < shadow_fill; i++) begin
                m = shadow_mask[i];
                if (match_live[i] && m != shadow_any && m == wgm_pkg::STAR_CODE) begin
                    match_live[i+1] = 1'b1;
                end
            end
            nxt = '0;
            for (int i = 0; i < shadow_fill; i++) begin
                m = shadow_mask[i];
                if (match_live[i]) begin
                    if (m == shadow_any) begin
                        nxt[i+1] = 1'b1;
                    end else if (m == wgm_pkg::STAR_CODE) begin
                        nxt[i] = 1'b1;
                    end else if (lower_if_folding(m) == lower_if_folding(it.symbol)) begin
                        nxt[i+1] = 1'b1;
                    end
                end
            end
            match_live = nxt;
            if (text_len != wgm_pkg::COUNT_CAP) begin
                text_len++;
            end
            if (it.last) begin
                if (mask_spill) begin
                    v.status = wgm_pkg::STATUS_OVERFLOW;
                    v.length = '0;
                end else if ((|match_live) && shadow_fill > 0) begin
                    v.status = wgm_pkg::STATUS_MATCH;
                    v.length = text_len;
                end else begin
                    v.status = wgm_pkg::STATUS_NO_MATCH;
                    v.length = '0;
                end
                awaited_verdicts.push_back(v);
                match_live = LIVE_START;
                text_len   = '0;
            end
        end
    endtask

    // Sender. Holds a symbol until it is taken and inserts random idle bursts.
    always @(posedge i_clk) begin : symbol_driver
        logic nv;
        nv = s_axis_tvalid;
        if (!i_rst_n) begin
            nv           = 1'b0;
            drv_holding  = 1'b0;
            tx_idle_left = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                match_step(drv_item);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (tx_idle_left > 0) begin
                    tx_idle_left--;
                    nv = 1'b0;
                end else if (!calm && symbol_queue.size() > 0
                             && $urandom_range(0, 7) == 0) begin
                    tx_idle_left = $urandom_range(0, 3);
                    nv = 1'b0;
                end else if (symbol_queue.size() > 0) begin
                    drv_item = symbol_queue.pop_front();
                    nv = 1'b1;
                end else begin
                    nv = 1'b0;
                end
                drv_holding = nv;
            end
        end
        s_axis_tvalid <= nv;
        s_axis_tdata  <= drv_item.symbol;
        s_axis_tuser  <= drv_item.mode;
        s_axis_tlast  <= drv_item.last;
    end

    // Receiver pacing: short random stalls, plus a long hold-off whenever one is asked.
    always @(posedge i_clk) begin : result_pace
        logic nr;
        nr = 1'b1;
        if (!i_rst_n) begin
            nr = 1'b0;
        end else if (long_hold_served != long_hold_tickets) begin
            long_hold_served = long_hold_tickets;
            hold_left = LONG_HOLD - 1;
            nr = 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            nr = 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
            hold_left = $urandom_range(0, 3);
            nr = 1'b0;
        end
        m_axis_tready <= nr;
    end

    // Monitor: every result transfer is checked against the oldest awaited verdict.
    always @(posedge i_clk) begin : result_check
        t_verdict want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (awaited_verdicts.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("unexpected result: status %0d length %0d",
                             m_axis_tuser, m_axis_tdata);
                end
            end else begin
                want = awaited_verdicts.pop_front();
                if (m_axis_tuser !== want.status || m_axis_tdata !== want.length) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display({"result mismatch: status exp %0d got %0d, ",
                                  "length exp %0d got %0d"},
                                 want.status, m_axis_tuser, want.length, m_axis_tdata);
                    end
                end
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin : watchdog
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL wildcard_glob_matcher_top");
            $finish;
        end
    end

    function automatic void queue_item(input logic mode,
                                       input logic [wgm_pkg::SYMBOL_BITS-1:0] sym,
                                       input logic last);
        t_sym_item it;
        it.mode   = mode;
        it.symbol = sym;
        it.last   = last;
        symbol_queue.push_back(it);
        items_queued++;
    endfunction

    function automatic logic [wgm_pkg::SYMBOL_BITS-1:0] pick_letter();
        return ($urandom_range(0, 1) ? wgm_pkg::CHAR_UPPER_A : CH_A)
               + wgm_pkg::SYMBOL_BITS'($urandom_range(0, 2));
    endfunction

    function automatic logic [wgm_pkg::SYMBOL_BITS-1:0] pick_mask_sym();
        case ($urandom_range(0, 11))
            0, 1:    return wgm_pkg::STAR_CODE;
            2:       return shadow_any;
            3:       return wgm_pkg::SYMBOL_BITS'($urandom);
            4:       return wgm_pkg::SYMBOL_BITS'($urandom_range(0, 3));
            default: return pick_letter();
        endcase
    endfunction

    function automatic logic [wgm_pkg::SYMBOL_BITS-1:0] pick_text_sym();
        case ($urandom_range(0, 9))
            0:       return wgm_pkg::SYMBOL_BITS'($urandom);
            1:       return wgm_pkg::STAR_CODE;
            default: return pick_letter();
        endcase
    endfunction

    function automatic logic [wgm_pkg::SYMBOL_BITS-1:0] swap_case(
        input logic [wgm_pkg::SYMBOL_BITS-1:0] c);
        if (c >= wgm_pkg::CHAR_UPPER_A && c <= wgm_pkg::CHAR_UPPER_Z) begin
            return c + wgm_pkg::CASE_OFFSET;
        end
        if (c >= CH_A && c <= wgm_pkg::CHAR_UPPER_Z + wgm_pkg::CASE_OFFSET) begin
            return c - wgm_pkg::CASE_OFFSET;
        end
        return c;
    endfunction

    // Mostly short masks, now and then one around the store depth so that it sometimes overflows.
    function automatic int mask_len();
        case ($urandom_range(0, 19))
            0:       return $urandom_range(wgm_pkg::MASK_DEPTH - 2, wgm_pkg::MASK_DEPTH + 2);
            1:       return 1;
            default: return $urandom_range(2, 6);
        endcase
    endfunction

    function automatic void draft_mask(input int len);
        mask_draft.delete();
        repeat (len) mask_draft.push_back(pick_mask_sym());
    endfunction

    function automatic void queue_mask(input int from, input int upto, input logic close);
        for (int i = from; i < upto; i++) begin
            queue_item(wgm_pkg::MODE_MASK, mask_draft[i], close && i == upto - 1);
        end
    endfunction

    // Builds a text that follows the drafted mask, then sometimes cuts it short or spoils
    // one symbol so that both verdicts come up often.
    function automatic void queue_text();
        logic [wgm_pkg::SYMBOL_BITS-1:0] txt[$];
        logic [wgm_pkg::SYMBOL_BITS-1:0] m;
        int                              cut;
        foreach (mask_draft[i]) begin
            m = mask_draft[i];
            if (m == shadow_any) begin
                txt.push_back(pick_text_sym());
            end else if (m == wgm_pkg::STAR_CODE) begin
                repeat ($urandom_range(0, 2)) txt.push_back(pick_text_sym());
            end else if ($urandom_range(0, shadow_fold ? 1 : 7) == 0) begin
                txt.push_back(swap_case(m));
            end else begin
                txt.push_back(m);
            end
        end
        if (txt.size() > 1 && $urandom_range(0, 3) == 0) begin
            cut = $urandom_range(1, txt.size() - 1);
            while (txt.size() > cut) txt.pop_back();
        end
        if (txt.size() > 0 && $urandom_range(0, 5) == 0) begin
            txt[$urandom_range(0, txt.size() - 1)] = pick_text_sym();
        end
        while (txt.size() > TEXT_MAX) txt.pop_back();
        if (txt.size() == 0) begin
            txt.push_back(pick_letter());
        end
        foreach (txt[i]) begin
            queue_item(wgm_pkg::MODE_TEXT, txt[i], i == txt.size() - 1);
        end
    endfunction

    // Random traffic: mostly a closed mask followed by texts, plus open masks with text
    // in between, texts cut off by a new mask, and raw noise.
    function automatic void queue_random(input int n);
        int goal;
        int len;
        int split;
        goal = items_queued + n;
        while (items_queued < goal) begin
            case ($urandom_range(0, 19))
                0, 1: begin
                    len = $urandom_range(2, 6);
                    draft_mask(len);
                    split = $urandom_range(1, len - 1);
                    queue_mask(0, split, 1'b0);
                    queue_text();
                    queue_mask(split, len, 1'b1);
                    queue_text();
                end
                2, 3: begin
                    repeat ($urandom_range(3, 6)) begin
                        queue_item(1'($urandom), pick_text_sym(), 1'($urandom));
                    end
                end
                4: begin
                    repeat ($urandom_range(1, 3)) begin
                        queue_item(wgm_pkg::MODE_TEXT, pick_text_sym(), 1'b0);
                    end
                    len = mask_len();
                    draft_mask(len);
                    queue_mask(0, len, 1'b1);
                    queue_text();
                end
                default: begin
                    len = mask_len();
                    draft_mask(len);
                    queue_mask(0, len, 1'b1);
                    repeat ($urandom_range(1, 3)) queue_text();
                end
            endcase
        end
    endfunction

    // Waits until every symbol has been taken and every verdict has arrived, then gives a
    // trailing mask or text symbol time to settle inside the block.
    task automatic settle();
        do @(posedge i_clk);
        while (symbol_queue.size() != 0 || drv_holding || awaited_verdicts.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == wgm_pkg::CFG_ANY_SYMBOL) begin
            shadow_any = val;
        end else begin
            shadow_fold = val[0];
        end
    endtask

    task automatic set_regs(input logic [15:0] any_code, input logic fold);
        settle();
        write_reg(wgm_pkg::CFG_ANY_SYMBOL, any_code);
        write_reg(wgm_pkg::CFG_CASE_FOLD, {15'd0, fold});
    endtask

    // Sequencer.
    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part with the reset configuration.
        // A text before any mask has nothing to match.
        queue_item(wgm_pkg::MODE_TEXT, CH_A, 1'b1);
        // A trailing star swallows the rest of the text.
        queue_item(wgm_pkg::MODE_MASK, CH_A, 1'b0);
        queue_item(wgm_pkg::MODE_MASK, wgm_pkg::STAR_CODE, 1'b1);
        queue_item(wgm_pkg::MODE_TEXT, CH_A, 1'b0);
        queue_item(wgm_pkg::MODE_TEXT, CH_B, 1'b1);
        // The any-symbol takes the zero code and the all-ones code alike.
        queue_item(wgm_pkg::MODE_MASK, wgm_pkg::ANY_RESET, 1'b1);
        queue_item(wgm_pkg::MODE_TEXT, '0, 1'b1);
        queue_item(wgm_pkg::MODE_TEXT, '1, 1'b1);
        // Without folding an uppercase mask letter does not match lowercase text.
        queue_item(wgm_pkg::MODE_MASK, wgm_pkg::CHAR_UPPER_A, 1'b1);
        queue_item(wgm_pkg::MODE_TEXT, CH_A, 1'b1);
        // A mask symbol in the middle of a text drops that text.
        queue_item(wgm_pkg::MODE_TEXT, CH_X, 1'b0);
        queue_item(wgm_pkg::MODE_MASK, CH_B, 1'b1);
        queue_item(wgm_pkg::MODE_TEXT, CH_B, 1'b1);
        // A text against a mask that is still open, then the mask grows.
        queue_item(wgm_pkg::MODE_MASK, CH_C, 1'b0);
        queue_item(wgm_pkg::MODE_TEXT, CH_C, 1'b1);
        queue_item(wgm_pkg::MODE_MASK, CH_D, 1'b1);
        queue_item(wgm_pkg::MODE_TEXT, CH_C, 1'b0);
        queue_item(wgm_pkg::MODE_TEXT, CH_D, 1'b1);
        // A text that matches only a prefix of the mask is still accepted.
        queue_item(wgm_pkg::MODE_MASK, CH_A, 1'b0);
        queue_item(wgm_pkg::MODE_MASK, CH_B, 1'b0);
        queue_item(wgm_pkg::MODE_MASK, CH_C, 1'b1);
        queue_item(wgm_pkg::MODE_TEXT, CH_A, 1'b0);
        queue_item(wgm_pkg::MODE_TEXT, CH_B, 1'b1);
        // All-ones as a literal mask symbol.
        queue_item(wgm_pkg::MODE_MASK, '1, 1'b1);
        queue_item(wgm_pkg::MODE_TEXT, '1, 1'b1);
        queue_random(220);

        // Folding on; the receiver holds off for a long stretch while text keeps coming.
        set_regs(wgm_pkg::ANY_RESET, 1'b1);
        queue_random(220);
        long_hold_tickets++;

        // The star code itself becomes the one-symbol wildcard.
        set_regs(wgm_pkg::STAR_CODE, 1'b1);
        queue_random(200);

        set_regs(16'hFFFF, 1'b0);
        queue_random(200);
        long_hold_tickets++;

        set_regs(16'h0000, 1'b1);
        queue_random(200);

        set_regs(16'($urandom), 1'($urandom));
        queue_random(200);

        // Last part without idling.
        set_regs(wgm_pkg::ANY_RESET, 1'b0);
        calm = 1'b1;
        queue_random(100);

        settle();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && awaited_verdicts.size() == 0) begin
            $display("PASS wildcard_glob_matcher_top");
        end else begin
            $display("FAIL wildcard_glob_matcher_top");
        end
        $finish;
    end

endmodule

@@ sim.f @@
sv/wgm_pkg.sv
sv/wgm_cell.sv
sv/wildcard_glob_matcher_top.sv
sv/wgm_checker.sv
tb/tb_top.sv
